// ===== rtl/rgbrle_pkg.sv =====
// Shared types and constants for the RGB scanline run-length encoder.
// No dependencies; every other file refers to this package by scoped names.
package rgbrle_pkg;

  localparam logic [7:0]  MAX_RUN        = 8'd254;
  localparam logic [15:0] LINE_WIDTH_RST = 16'd640;
  localparam int          QUEUE_DEPTH    = 4;

  // Configuration register map (byte address = 4 * index)
  localparam int          CFG_ADDR_W     = 3;
  localparam logic [0:0]  REG_LINE_WIDTH = 1'b0;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0] run_length;
    logic [7:0] run_blue;
    logic [7:0] run_green;
    logic [7:0] run_red;
    logic       line_end;
    logic       last;
  } record_t;

  // Work for the back end: a run closed mid-line and/or a line flush.
  typedef struct packed {
    logic       has_close;
    logic [7:0] close_count;
    pixel_t     close_colour;
    logic       has_flush;
    logic [7:0] flush_count;
    pixel_t     flush_colour;
  } entry_t;

  // Front end to queue write side
  typedef struct packed {
    logic   wr;
    entry_t entry;
  } qwr_t;

endpackage

// ===== rtl/rgbrle_front.sv =====
// Front end: takes pixels, tracks run colour, run length and column,
// and writes one queue entry per pixel that closes a run or ends a line. Uses rgbrle_pkg.
module rgbrle_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [15:0]         line_width,
  input  logic                accept,
  input  rgbrle_pkg::pixel_t  pixel,
  output rgbrle_pkg::qwr_t    qwr
);

  rgbrle_pkg::pixel_t run_colour_r, run_colour_nxt;
  logic [7:0]         run_count_r, run_count_nxt;
  logic [15:0]        column_r, column_nxt;

  logic [15:0]        width;
  logic [16:0]        col_inc;
  logic               at_end;
  logic               start;
  logic               close;
  logic [7:0]         new_count;
  rgbrle_pkg::pixel_t new_colour;

  // A zero width acts as one pixel per line
  assign width   = (line_width == 16'd0) ? 16'd1 : line_width;
  assign col_inc = {1'b0, column_r} + 17'd1;
  assign at_end  = col_inc >= {1'b0, width};
  assign start   = (column_r == 16'd0) || (run_count_r == 8'd0);
  assign close   = !start && ((pixel != run_colour_r) ||
                              (run_count_r >= rgbrle_pkg::MAX_RUN));

  assign new_count  = (start || close) ? 8'd1 : run_count_r + 8'd1;
  assign new_colour = (start || close) ? pixel : run_colour_r;

  always_comb begin
    run_colour_nxt = run_colour_r;
    run_count_nxt  = run_count_r;
    column_nxt     = column_r;
    if (accept) begin
      run_colour_nxt = new_colour;
      run_count_nxt  = at_end ? 8'd0 : new_count;
      column_nxt     = at_end ? 16'd0 : col_inc[15:0];
    end
  end

  always_comb begin
    qwr.wr                 = accept && (close || at_end);
    qwr.entry.has_close    = close;
    qwr.entry.close_count  = run_count_r;
    qwr.entry.close_colour = run_colour_r;
    qwr.entry.has_flush    = at_end;
    qwr.entry.flush_count  = new_count;
    qwr.entry.flush_colour = new_colour;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_colour_r <= '0;
      run_count_r  <= 8'd0;
      column_r     <= 16'd0;
    end else begin
      run_colour_r <= run_colour_nxt;
      run_count_r  <= run_count_nxt;
      column_r     <= column_nxt;
    end
  end

endmodule

// ===== rtl/rgbrle_fifo.sv =====
// Short entry queue between front and back ends.
// Uses rgbrle_pkg for the entry type.
module rgbrle_fifo #(
  parameter int DEPTH = rgbrle_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rgbrle_pkg::qwr_t    qwr,
  output logic                full,
  input  logic                rd,
  output logic                empty,
  output rgbrle_pkg::entry_t  rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  rgbrle_pkg::entry_t mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_wr;
  logic               do_rd;

  assign full    = count_r == CNT_W'(DEPTH);
  assign empty   = count_r == '0;
  assign do_wr   = qwr.wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    if (do_rd) rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    if (do_wr && !do_rd) count_nxt = count_r + 1'b1;
    else if (do_rd && !do_wr) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_ptr_r] <= qwr.entry;
  end

endmodule

// ===== rtl/rgbrle_back.sv =====
// Back end: unpacks queue entries into records and holds the output register.
// Uses rgbrle_pkg for entry and record types.
module rgbrle_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  rgbrle_pkg::entry_t  q_data,
  output logic                q_rd,
  output logic                empty,
  input  logic                pop,
  output rgbrle_pkg::record_t out_data
);

  rgbrle_pkg::record_t out_rec_r, out_rec_nxt;
  rgbrle_pkg::record_t pend_rec_r, pend_rec_nxt;
  logic                out_vld_r, out_vld_nxt;
  logic                pend_vld_r, pend_vld_nxt;
  rgbrle_pkg::record_t close_rec;
  rgbrle_pkg::record_t flush_rec;
  logic                advance;

  always_comb begin
    close_rec.run_length = q_data.close_count;
    close_rec.run_blue   = q_data.close_colour.blue;
    close_rec.run_green  = q_data.close_colour.green;
    close_rec.run_red    = q_data.close_colour.red;
    close_rec.line_end   = 1'b0;
    close_rec.last       = !q_data.has_flush;
    flush_rec.run_length = q_data.flush_count;
    flush_rec.run_blue   = q_data.flush_colour.blue;
    flush_rec.run_green  = q_data.flush_colour.green;
    flush_rec.run_red    = q_data.flush_colour.red;
    flush_rec.line_end   = 1'b1;
    flush_rec.last       = 1'b1;
  end

  assign advance  = !out_vld_r || pop;
  assign q_rd     = advance && !pend_vld_r && !q_empty;
  assign empty    = !out_vld_r;
  assign out_data = out_rec_r;

  always_comb begin
    out_rec_nxt  = out_rec_r;
    out_vld_nxt  = out_vld_r;
    pend_rec_nxt = pend_rec_r;
    pend_vld_nxt = pend_vld_r;
    if (advance) begin
      priority if (pend_vld_r) begin
        out_rec_nxt  = pend_rec_r;
        out_vld_nxt  = 1'b1;
        pend_vld_nxt = 1'b0;
      end else if (!q_empty) begin
        out_vld_nxt = 1'b1;
        if (q_data.has_close) begin
          // closed run goes first, line flush waits one transfer
          out_rec_nxt  = close_rec;
          pend_rec_nxt = flush_rec;
          pend_vld_nxt = q_data.has_flush;
        end else begin
          out_rec_nxt = flush_rec;
        end
      end else begin
        out_vld_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      pend_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      pend_vld_r <= pend_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_rec_r  <= out_rec_nxt;
    pend_rec_r <= pend_rec_nxt;
  end

endmodule

// ===== rtl/rgb_scanline_rle_encoder_unit.sv =====
// RGB scanline run-length encoder: one pixel can be taken on every clock
// while the entry queue has room; the front end compares each pixel with the
// current run and increments its length. Records leave at one per cycle while
// pop is held, from the back end's output register, so a pixel that yields two
// records (a closed run plus the line flush) sends them in turn; the
// QUEUE_DEPTH-entry queue absorbs such bursts and any pop stalls. line_width
// (address 0) is reset to 640; a width of zero acts as one. Depends on
// rgbrle_pkg, rgbrle_front, rgbrle_fifo and rgbrle_back.
module rgb_scanline_rle_encoder_unit #(
  parameter int QUEUE_DEPTH = rgbrle_pkg::QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // pixel input
  input  logic                                push,
  output logic                                full,
  input  rgbrle_pkg::pixel_t                  in_data,
  // record output
  output logic                                empty,
  input  logic                                pop,
  output rgbrle_pkg::record_t                 out_data,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rgbrle_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  logic [15:0]        line_width_r;
  logic               cfg_wr;
  logic               accept;
  logic               q_full;
  logic               q_empty;
  logic               q_rd;
  rgbrle_pkg::qwr_t   qwr;
  rgbrle_pkg::entry_t q_data;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite &&
                  (paddr[rgbrle_pkg::CFG_ADDR_W-1] == rgbrle_pkg::REG_LINE_WIDTH);
  assign prdata = (paddr[rgbrle_pkg::CFG_ADDR_W-1] == rgbrle_pkg::REG_LINE_WIDTH) ?
                  {16'd0, line_width_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= rgbrle_pkg::LINE_WIDTH_RST;
    end else if (cfg_wr) begin
      line_width_r <= pwdata[15:0];
    end
  end

  assign full   = q_full;
  assign accept = push && !q_full;

  rgbrle_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .line_width (line_width_r),
    .accept     (accept),
    .pixel      (in_data),
    .qwr        (qwr)
  );

  rgbrle_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .qwr     (qwr),
    .full    (q_full),
    .rd      (q_rd),
    .empty   (q_empty),
    .rd_data (q_data)
  );

  rgbrle_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_data   (q_data),
    .q_rd     (q_rd),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

// ===== rtl/rgbrle_chk.sv =====
// Port-level checks for the RGB scanline run-length encoder, bound to the top.
// Uses rgbrle_pkg for the port types.
module rgbrle_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input rgbrle_pkg::record_t out_data
);

  // a waiting record that is not taken stays put
  ast_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_data))
    else $error("record changed while stalled");

  ast_len: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> out_data.run_length != 8'd0 &&
               out_data.run_length <= rgbrle_pkg::MAX_RUN)
    else $error("run length out of range");

  // a line flush is always the final record of its pixel
  ast_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_data.line_end |-> out_data.last)
    else $error("line flush without last");

  ast_rst_empty: assert property (@(posedge clk)
    !rst_n |=> empty && !full)
    else $error("queue not clear after reset");

endmodule

bind rgb_scanline_rle_encoder_unit rgbrle_chk u_rgbrle_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_data (out_data)
);

// ===== bench/testbench.sv =====
// Testbench for rgb_scanline_rle_encoder_unit: pixel streams with directed and random runs,
// checked record by record against a run-length predictor kept in this file.
// Depends on rgbrle_pkg and the encoder RTL.
module testbench;

  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT = 5000;
  localparam int RANDOM_PIXELS = 1000;
  localparam logic [rgbrle_pkg::CFG_ADDR_W-1:0] LINE_WIDTH_ADDR =
    rgbrle_pkg::CFG_ADDR_W'(4 * int'(rgbrle_pkg::REG_LINE_WIDTH));

  logic clk;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  rgbrle_pkg::pixel_t in_data = '0;
  logic empty;
  logic pop = 1'b0;
  rgbrle_pkg::record_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [rgbrle_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // predictor state
  logic [15:0] line_width_q;
  rgbrle_pkg::pixel_t run_colour_q;
  logic [7:0] run_count_q;
  logic [15:0] column_q;
  rgbrle_pkg::record_t expected_records[$];

  bit steady = 1'b0;
  int error_count = 0;
  int stall_cycles = 0;

  rgb_scanline_rle_encoder_unit DUT (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .full(full),
    .in_data(in_data),
    .empty(empty),
    .pop(pop),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic rgbrle_pkg::pixel_t make_pixel(input logic [7:0] r,
                                                    input logic [7:0] g,
                                                    input logic [7:0] b);
    rgbrle_pkg::pixel_t px;
    px.red = r;
    px.green = g;
    px.blue = b;
    return px;
  endfunction

  function automatic rgbrle_pkg::pixel_t random_pixel();
    logic [23:0] bits;
    bits = 24'($urandom);
    return bits;
  endfunction

  function automatic void queue_record(input logic [7:0] count,
                                       input rgbrle_pkg::pixel_t colour,
                                       input logic line_end, input logic last);
    rgbrle_pkg::record_t rec;
    rec.run_length = count;
    rec.run_blue = colour.blue;
    rec.run_green = colour.green;
    rec.run_red = colour.red;
    rec.line_end = line_end;
    rec.last = last;
    expected_records.push_back(rec);
  endfunction

  // Advance the encoder state by one pixel and queue the records it closes.
  function automatic void encode_pixel(input rgbrle_pkg::pixel_t px);
    int width;
    bit at_end;
    width = (line_width_q == 16'd0) ? 1 : int'(line_width_q);
    at_end = (int'(column_q) + 1) >= width;
    if (column_q == 16'd0 || run_count_q == 8'd0) begin
      run_colour_q = px;
      run_count_q = 8'd1;
    end else if (px != run_colour_q || run_count_q >= rgbrle_pkg::MAX_RUN) begin
      queue_record(run_count_q, run_colour_q, 1'b0, !at_end);
      run_colour_q = px;
      run_count_q = 8'd1;
    end else begin
      run_count_q = run_count_q + 8'd1;
    end
    if (at_end) begin
      queue_record(run_count_q, run_colour_q, 1'b1, 1'b1);
      run_count_q = 8'd0;
      column_q = 16'd0;
    end else begin
      column_q = column_q + 16'd1;
    end
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Record side: a transfer is decided by the levels seen at the falling edge.
  always @(negedge clk) begin : check_records
    rgbrle_pkg::record_t got;
    rgbrle_pkg::record_t want;
    if (rst_n && pop && !empty) begin
      got = out_data;
      if (expected_records.size() == 0) begin
        $display("%0t: unexpected record: expected none, actual %h", $time, got);
        error_count++;
      end else begin
        want = expected_records.pop_front();
        check_field("run_length", want.run_length, got.run_length);
        check_field("run_blue", want.run_blue, got.run_blue);
        check_field("run_green", want.run_green, got.run_green);
        check_field("run_red", want.run_red, got.run_red);
        check_field("line_end", 8'(want.line_end), 8'(got.line_end));
        check_field("last", 8'(want.last), 8'(got.last));
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    pop <= steady || ($urandom_range(99) >= 6);
  end

  task automatic send_pixel(input rgbrle_pkg::pixel_t px);
    if (!steady && $urandom_range(99) < 6) begin
      push <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    push <= 1'b1;
    in_data <= px;
    @(negedge clk);
    while (full) @(negedge clk);
    encode_pixel(px);
    @(posedge clk);
  endtask

  task automatic send_run(input rgbrle_pkg::pixel_t px, input int count);
    for (int i = 0; i < count; i++) send_pixel(px);
  endtask

  // Stop the stream and let every expected record come out.
  task automatic drain_records();
    push <= 1'b0;
    while (expected_records.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure_width(input logic [31:0] value);
    logic [31:0] readback;
    drain_records();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= LINE_WIDTH_ADDR;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    @(posedge clk);
    line_width_q = value[15:0];
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    readback = prdata;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (readback !== {16'd0, line_width_q}) begin
      $display("%0t: line_width readback mismatch: expected %0d, actual %0d", $time,
               line_width_q, readback);
      error_count++;
    end
  endtask

  task automatic test_reset_width();
    logic [31:0] readback;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= LINE_WIDTH_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    readback = prdata;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (readback !== {16'd0, rgbrle_pkg::LINE_WIDTH_RST}) begin
      $display("%0t: reset line_width mismatch: expected %0d, actual %0d", $time,
               rgbrle_pkg::LINE_WIDTH_RST, readback);
      error_count++;
    end
  endtask

  task automatic test_channel_extremes();
    send_run(make_pixel(8'h00, 8'h00, 8'h00), 2);
    send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF));
    send_pixel(make_pixel(8'hFF, 8'h00, 8'h00));
    send_pixel(make_pixel(8'h00, 8'hFF, 8'h00));
    send_pixel(make_pixel(8'h00, 8'h00, 8'hFF));
  endtask

  task automatic test_short_lines();
    rgbrle_pkg::pixel_t a, b, c;
    a = make_pixel(8'h12, 8'h34, 8'h56);
    b = make_pixel(8'h12, 8'h34, 8'h57);
    c = make_pixel(8'h92, 8'h34, 8'h56);
    // upper data bits fall outside the 16-bit register
    configure_width(32'hFFFF_0003);
    send_pixel(a);           // open line from before ends here
    send_run(a, 3);
    send_run(a, 2);
    send_pixel(b);           // close and flush from one pixel
    send_pixel(a);
    send_pixel(b);
    send_pixel(c);
  endtask

  task automatic test_single_pixel_lines();
    configure_width(32'd1);
    send_run(make_pixel(8'hFF, 8'hFF, 8'hFF), 2);
    configure_width(32'd0);  // zero acts as one
    send_pixel(make_pixel(8'h00, 8'h00, 8'h00));
    send_pixel(make_pixel(8'h5A, 8'hA5, 8'h3C));
  endtask

  task automatic test_width_lowered();
    rgbrle_pkg::pixel_t a, b, c, d;
    a = make_pixel(8'h01, 8'h02, 8'h03);
    b = make_pixel(8'h80, 8'h40, 8'h20);
    c = make_pixel(8'h7F, 8'hBF, 8'hDF);
    d = make_pixel(8'h01, 8'h02, 8'h03);
    configure_width(32'd20);
    send_run(a, 2);
    send_run(b, 3);
    configure_width(32'd4);  // column already past the new line end
    send_pixel(b);
    send_run(c, 2);
    send_run(d, 2);
  endtask

  task automatic test_long_runs();
    rgbrle_pkg::pixel_t a, b;
    a = make_pixel(8'hC3, 8'h3C, 8'h99);
    b = make_pixel(8'hC3, 8'h3C, 8'h98);
    configure_width(32'd65535);
    send_run(a, 300);        // one record at the 254 limit
    send_pixel(b);
    configure_width(32'd255);
    send_pixel(b);
    send_run(a, 255);        // limit record then a one-pixel flush
  endtask

  task automatic test_random_scanlines();
    rgbrle_pkg::pixel_t palette[4];
    rgbrle_pkg::pixel_t colour;
    logic [23:0] flip;
    int width, phase, run_len, phase_pixels, sent, total;
    bit paused;
    phase = 0;
    total = 0;
    colour = random_pixel();
    while (total < RANDOM_PIXELS) begin
      case ($urandom_range(9))
        0: width = 1;
        1, 2: width = $urandom_range(256, 253);
        default: width = $urandom_range(24, 2);
      endcase
      configure_width(width);
      steady = (phase == 3 || phase == 4);
      for (int i = 0; i < 4; i++) palette[i] = random_pixel();
      flip = 24'd1 << $urandom_range(23);
      palette[1] = palette[0] ^ flip;
      phase_pixels = (width > 200) ? $urandom_range(2 * width, width) : $urandom_range(120, 30);
      sent = 0;
      paused = 1'b0;
      while (sent < phase_pixels) begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4, 5: colour = palette[$urandom_range(3)];
          6, 7: begin
            flip = 24'd1 << $urandom_range(23);
            colour = colour ^ flip;
          end
          default: colour = random_pixel();
        endcase
        if (width > 200 && $urandom_range(3) == 0) run_len = $urandom_range(300, 200);
        else run_len = $urandom_range(6, 1);
        if (run_len > phase_pixels - sent) run_len = phase_pixels - sent;
        send_run(colour, run_len);
        sent += run_len;
        if (!paused && phase % 3 == 0 && sent >= phase_pixels / 2) begin
          drain_records();   // sender holds off until the queue of records is empty
          paused = 1'b1;
        end
      end
      total += sent;
      phase++;
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    line_width_q = rgbrle_pkg::LINE_WIDTH_RST;
    run_colour_q = '0;
    run_count_q = 8'd0;
    column_q = 16'd0;
    @(posedge clk);
    test_reset_width();
    test_channel_extremes();
    test_short_lines();
    test_single_pixel_lines();
    test_width_lowered();
    test_long_runs();
    test_random_scanlines();
    drain_records();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rgbrle_pkg.sv
rtl/rgbrle_front.sv
rtl/rgbrle_fifo.sv
rtl/rgbrle_back.sv
rtl/rgb_scanline_rle_encoder_unit.sv
rtl/rgbrle_chk.sv
bench/testbench.sv
